FILE: hdl/genotype_unpack_standardize_macros.svh
// assertion macros shared by the checker of the genotype unpack block
// expects clk and rst_n in the scope where a macro is used
`ifndef GENOTYPE_UNPACK_STANDARDIZE_MACROS_SVH
`define GENOTYPE_UNPACK_STANDARDIZE_MACROS_SVH

// same-cycle implication
`define GUS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GUS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/gus_pkg.sv
// shared types and constants of the genotype unpack and standardize block
// no dependencies
package gus_pkg;

    localparam int FREQ_FRAC_BITS_DEF = 16;
    localparam int OUT_FRAC_BITS_DEF  = 16;

    localparam int FREQ_W = 16;
    localparam int GENO_W = 8;
    localparam int SIB_W  = 3;
    localparam int VAL_W  = 28;
    localparam int MODE_W = 2;

    localparam int SAMPLES_PER_BYTE = 4;

    localparam logic [MODE_W-1:0] MODE_DOSAGE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STD    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CENTER = 2'd2;

    localparam logic KIND_SNP  = 1'b0;
    localparam logic KIND_GENO = 1'b1;

    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef struct packed {
        logic              kind;
        logic [FREQ_W-1:0] allele_freq;
        logic [GENO_W-1:0] geno_byte;
        logic [SIB_W-1:0]  samples_in_byte;
    } in_req_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value0;
        logic signed [VAL_W-1:0] value1;
        logic signed [VAL_W-1:0] value2;
        logic signed [VAL_W-1:0] value3;
        logic [SIB_W-1:0]        valid_count;
        logic                    degenerate;
    } out_req_t;

    // standardized table: the missing code always reads as zero
    typedef struct packed {
        logic                    zero_spread;
        logic signed [VAL_W-1:0] ent_hom0;
        logic signed [VAL_W-1:0] ent_het;
        logic signed [VAL_W-1:0] ent_hom1;
    } code_tbl_t;

endpackage

FILE: hdl/gus_table_calc.sv
// per-snp table unit: serial multiply, normalize, square root and three division lanes
// depends on gus_pkg
module gus_table_calc
    import gus_pkg::*;
#(
    parameter int FREQ_FRAC_BITS = FREQ_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS  = OUT_FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [FREQ_W-1:0] freq,
    output logic              busy,
    output code_tbl_t         tbl
);

    localparam int AW        = FREQ_W;
    localparam int FW        = FREQ_FRAC_BITS + 1;
    localparam int MW        = FREQ_FRAC_BITS + 2;
    localparam int EXT_W     = (MW > AW + 1) ? MW : AW + 1;
    localparam int NORM_W    = 62;
    localparam int ROOT_W    = NORM_W / 2;
    localparam int E_MAX     = 30;
    localparam int E_W       = $clog2(E_MAX + 1);
    localparam int DIV_BASE  = MW + OUT_FRAC_BITS + 1;
    localparam int DIV_MAX   = DIV_BASE + E_MAX;
    localparam int STEP_W    = $clog2(DIV_MAX + 1);
    localparam int NUM_LANES = 3;

    localparam logic [EXT_W-1:0] S_EXT = EXT_W'(1) << FREQ_FRAC_BITS;
    localparam logic [EXT_W-1:0] LANE_KS [NUM_LANES] = '{'0, S_EXT, S_EXT << 1};

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_NORM = 6'b000100,
        ST_SQRT = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_FIN  = 6'b100000
    } calc_state_t;

    calc_state_t        state_reg, state_next;
    code_tbl_t          tbl_reg, tbl_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [E_W-1:0]     e_reg, e_next;
    logic [AW-1:0]      a_sh_reg, a_sh_next;
    logic [FW-1:0]      fac_reg, fac_next;
    logic [NORM_W-1:0]  d_reg, d_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic [ROOT_W:0]    srem_reg, srem_next;

    logic [MW-1:0]      m_sh_reg  [NUM_LANES];
    logic [MW-1:0]      m_sh_next [NUM_LANES];
    logic               neg_reg   [NUM_LANES];
    logic               neg_next  [NUM_LANES];
    logic [ROOT_W-1:0]  drem_reg  [NUM_LANES];
    logic [ROOT_W-1:0]  drem_next [NUM_LANES];
    logic [VAL_W-1:0]   q_reg     [NUM_LANES];
    logic [VAL_W-1:0]   q_next    [NUM_LANES];
    logic               ovf_reg   [NUM_LANES];
    logic               ovf_next  [NUM_LANES];

    logic [EXT_W-1:0]   freq_ext;
    logic [EXT_W-1:0]   twoa;
    logic [EXT_W-1:0]   fac_diff;
    logic [FW-1:0]      fac_init;
    logic               degen;
    logic [EXT_W-1:0]   m_diff [NUM_LANES];
    logic [MW-1:0]      m_init [NUM_LANES];
    logic               m_neg  [NUM_LANES];
    logic [ROOT_W+2:0]  sq_sh;
    logic [ROOT_W+2:0]  sq_trial;
    logic [ROOT_W+2:0]  sq_diff;
    logic [ROOT_W:0]    div_sh   [NUM_LANES];
    logic [ROOT_W:0]    div_diff [NUM_LANES];
    logic               div_ge   [NUM_LANES];
    logic signed [VAL_W-1:0] lane_val [NUM_LANES];

    function automatic logic signed [VAL_W-1:0] lane_value(
        input logic             neg,
        input logic             ovf,
        input logic [VAL_W-1:0] q
    );
        logic [VAL_W-1:0] q_inc;
        logic [VAL_W-1:0] mag;
        q_inc = q + VAL_W'(1);
        mag   = {1'b0, q_inc[VAL_W-1:1]};
        if (ovf || (&q))
        begin
            lane_value = neg ? VAL_MIN : VAL_MAX;
        end
        else if (neg)
        begin
            lane_value = -$signed(mag);
        end
        else
        begin
            lane_value = $signed(mag);
        end
    endfunction

    // operands for a new frequency
    always_comb
    begin
        freq_ext = EXT_W'(freq);
        twoa     = {freq_ext[EXT_W-2:0], 1'b0};
        degen    = (freq == '0) || (freq_ext >= S_EXT);
        fac_diff = S_EXT - freq_ext;
        fac_init = {fac_diff[FW-2:0], 1'b0};
        for (int i = 0; i < NUM_LANES; i++)
        begin
            m_neg[i]  = LANE_KS[i] < twoa;
            m_diff[i] = m_neg[i] ? (twoa - LANE_KS[i]) : (LANE_KS[i] - twoa);
            m_init[i] = m_diff[i][MW-1:0];
        end
    end

    // one root bit per cycle
    always_comb
    begin
        sq_sh    = {srem_reg, d_reg[NORM_W-1 -: 2]};
        sq_trial = {1'b0, root_reg, 2'b01};
        sq_diff  = sq_sh - sq_trial;
    end

    // one quotient bit per lane per cycle
    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            div_sh[i]   = {drem_reg[i], m_sh_reg[i][MW-1]};
            div_ge[i]   = div_sh[i] >= {1'b0, root_reg};
            div_diff[i] = div_sh[i] - {1'b0, root_reg};
            lane_val[i] = lane_value(neg_reg[i], ovf_reg[i], q_reg[i]);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        tbl_next   = tbl_reg;
        step_next  = step_reg;
        e_next     = e_reg;
        a_sh_next  = a_sh_reg;
        fac_next   = fac_reg;
        d_next     = d_reg;
        root_next  = root_reg;
        srem_next  = srem_reg;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            m_sh_next[i] = m_sh_reg[i];
            neg_next[i]  = neg_reg[i];
            drem_next[i] = drem_reg[i];
            q_next[i]    = q_reg[i];
            ovf_next[i]  = ovf_reg[i];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (degen)
                    begin
                        tbl_next             = '0;
                        tbl_next.zero_spread = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                        step_next  = STEP_W'(AW);
                        e_next     = '0;
                        a_sh_next  = freq;
                        fac_next   = fac_init;
                        d_next     = '0;
                        for (int i = 0; i < NUM_LANES; i++)
                        begin
                            m_sh_next[i] = m_init[i];
                            neg_next[i]  = m_neg[i];
                        end
                    end
                end
            end
            ST_MUL:
            begin
                // 2a(S-a), frequency bits msb first
                d_next = {d_reg[NORM_W-2:0], 1'b0}
                       + (a_sh_reg[AW-1] ? {{(NORM_W-FW){1'b0}}, fac_reg} : '0);
                a_sh_next = {a_sh_reg[AW-2:0], 1'b0};
                if (step_reg == STEP_W'(1))
                begin
                    state_next = ST_NORM;
                end
                else
                begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            ST_NORM:
            begin
                if (d_reg[NORM_W-1 -: 2] == 2'b00)
                begin
                    d_next = {d_reg[NORM_W-3:0], 2'b00};
                    e_next = e_reg + E_W'(1);
                end
                else
                begin
                    state_next = ST_SQRT;
                    step_next  = STEP_W'(ROOT_W);
                    root_next  = '0;
                    srem_next  = '0;
                end
            end
            ST_SQRT:
            begin
                d_next = {d_reg[NORM_W-3:0], 2'b00};
                if (sq_sh >= sq_trial)
                begin
                    srem_next = sq_diff[ROOT_W:0];
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    srem_next = sq_sh[ROOT_W:0];
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                if (step_reg == STEP_W'(1))
                begin
                    state_next = ST_DIV;
                    step_next  = STEP_W'(DIV_BASE) + STEP_W'(e_reg);
                    for (int i = 0; i < NUM_LANES; i++)
                    begin
                        drem_next[i] = '0;
                        q_next[i]    = '0;
                        ovf_next[i]  = 1'b0;
                    end
                end
                else
                begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            ST_DIV:
            begin
                for (int i = 0; i < NUM_LANES; i++)
                begin
                    m_sh_next[i] = {m_sh_reg[i][MW-2:0], 1'b0};
                    drem_next[i] = div_ge[i] ? div_diff[i][ROOT_W-1:0]
                                             : div_sh[i][ROOT_W-1:0];
                    q_next[i]    = {q_reg[i][VAL_W-2:0], div_ge[i]};
                    // sticky: quotient already past the saturation range
                    ovf_next[i]  = ovf_reg[i] | q_reg[i][VAL_W-1];
                end
                if (step_reg == STEP_W'(1))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            ST_FIN:
            begin
                tbl_next.zero_spread = 1'b0;
                tbl_next.ent_hom0    = lane_val[0];
                tbl_next.ent_het     = lane_val[1];
                tbl_next.ent_hom1    = lane_val[2];
                state_next           = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tbl_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tbl_reg   <= tbl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        e_reg    <= e_next;
        a_sh_reg <= a_sh_next;
        fac_reg  <= fac_next;
        d_reg    <= d_next;
        root_reg <= root_next;
        srem_reg <= srem_next;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            m_sh_reg[i] <= m_sh_next[i];
            neg_reg[i]  <= neg_next[i];
            drem_reg[i] <= drem_next[i];
            q_reg[i]    <= q_next[i];
            ovf_reg[i]  <= ovf_next[i];
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign tbl  = tbl_reg;

endmodule

FILE: hdl/genotype_unpack_standardize.sv
// genotype unpack and standardize: top level with decode, mode register and output buffer
// depends on gus_pkg and gus_table_calc
//
// Input channel in_valid/in_stall/in_data carries two kinds of request. A snp-start
// request (kind 0) loads the allele frequency; a genotype request (kind 1) holds four
// 2-bit codes and gives one result request on out_valid/out_stall/out_data.
// cfg_write/cfg_data set the decode mode: dosage, standardized or centered.
// A genotype request is decoded in the cycle it is accepted and its result is registered;
// genotype bytes go at one per cycle while in_stall is low.
// A snp-start request with a usable frequency runs the table unit: a serial
// multiply, a normalize step, a bit-serial square root and three parallel
// bit-serial dividers, then a write of the table; the normalize shift count e
// lengthens the normalize step and the division. in_stall stays high meanwhile.
// A frequency of 0 or 1 skips the table unit: the table is cleared and marked
// as zero spread.
// Results sit in an output register backed by one skid entry, so one more genotype
// request is taken while the receiver stalls; then in_stall rises.
// Reset clears the mode to dosage, the table to zero and empties the output buffer.
module genotype_unpack_standardize
    import gus_pkg::*;
#(
    parameter int FREQ_FRAC_BITS = FREQ_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS  = OUT_FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [MODE_W-1:0] cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_req_t           in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output out_req_t          out_data
);

    localparam logic [1:0] CODE_HOM0 = 2'b00;
    localparam logic [1:0] CODE_HET  = 2'b10;
    localparam logic [1:0] CODE_HOM1 = 2'b11;

    localparam logic signed [VAL_W-1:0] ONE_VAL = (OUT_FRAC_BITS <= VAL_W - 2)
        ? $signed(VAL_W'(64'd1 << OUT_FRAC_BITS)) : VAL_MAX;
    localparam logic signed [VAL_W-1:0] TWO_VAL = (OUT_FRAC_BITS <= VAL_W - 3)
        ? $signed(VAL_W'(64'd2 << OUT_FRAC_BITS)) : VAL_MAX;
    localparam logic signed [VAL_W-1:0] MONE_VAL = (OUT_FRAC_BITS <= VAL_W - 1)
        ? $signed(VAL_W'(64'd0 - (64'd1 << OUT_FRAC_BITS))) : VAL_MIN;

    logic [MODE_W-1:0] mode_reg, mode_next;
    out_req_t          out_data_reg, out_data_next;
    out_req_t          skid_data_reg, skid_data_next;
    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;

    logic              calc_busy;
    code_tbl_t         code_tbl;
    logic              accept;
    logic              snp_start;
    logic              push;
    logic              pop;
    logic              out_load_res;
    logic              out_load_skid;
    logic              skid_load;
    logic [SIB_W-1:0]  cnt;
    logic signed [VAL_W-1:0] ent0, ent2, ent3;
    out_req_t          res;

    function automatic logic signed [VAL_W-1:0] pick(
        input logic [1:0]              code,
        input logic signed [VAL_W-1:0] hom0,
        input logic signed [VAL_W-1:0] het,
        input logic signed [VAL_W-1:0] hom1
    );
        case (code)
            CODE_HOM0: pick = hom0;
            CODE_HET:  pick = het;
            CODE_HOM1: pick = hom1;
            default:   pick = '0;    // missing genotype
        endcase
    endfunction

    gus_table_calc #(
        .FREQ_FRAC_BITS (FREQ_FRAC_BITS),
        .OUT_FRAC_BITS  (OUT_FRAC_BITS)
    ) u_calc (
        .clk   (clk),
        .rst_n (rst_n),
        .start (snp_start),
        .freq  (in_data.allele_freq),
        .busy  (calc_busy),
        .tbl   (code_tbl)
    );

    assign in_stall  = calc_busy || skid_valid_reg;
    assign accept    = in_valid && !in_stall;
    assign snp_start = accept && (in_data.kind == KIND_SNP);
    assign push      = accept && (in_data.kind == KIND_GENO);
    assign pop       = out_valid_reg && !out_stall;

    assign mode_next = cfg_write ? cfg_data : mode_reg;

    always_comb
    begin
        case (mode_reg)
            MODE_STD:
            begin
                ent0 = code_tbl.ent_hom0;
                ent2 = code_tbl.ent_het;
                ent3 = code_tbl.ent_hom1;
            end
            MODE_CENTER:
            begin
                ent0 = MONE_VAL;
                ent2 = '0;
                ent3 = ONE_VAL;
            end
            default:
            begin
                ent0 = '0;
                ent2 = ONE_VAL;
                ent3 = TWO_VAL;
            end
        endcase
    end

    always_comb
    begin
        cnt = (in_data.samples_in_byte > SIB_W'(SAMPLES_PER_BYTE))
            ? SIB_W'(SAMPLES_PER_BYTE) : in_data.samples_in_byte;
        res.value0 = (cnt > SIB_W'(0))
            ? pick(in_data.geno_byte[1:0], ent0, ent2, ent3) : '0;
        res.value1 = (cnt > SIB_W'(1))
            ? pick(in_data.geno_byte[3:2], ent0, ent2, ent3) : '0;
        res.value2 = (cnt > SIB_W'(2))
            ? pick(in_data.geno_byte[5:4], ent0, ent2, ent3) : '0;
        res.value3 = (cnt > SIB_W'(3))
            ? pick(in_data.geno_byte[7:6], ent0, ent2, ent3) : '0;
        res.valid_count = cnt;
        res.degenerate  = (mode_reg == MODE_STD) && code_tbl.zero_spread;
    end

    // output register plus one skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_load_res    = 1'b0;
        out_load_skid   = 1'b0;
        skid_load       = 1'b0;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_load_skid   = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_load_res   = push;
            end
        end
        else if (!out_valid_reg)
        begin
            out_valid_next = push;
            out_load_res   = push;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_load       = 1'b1;
        end
        out_data_next  = out_load_skid ? skid_data_reg
                       : (out_load_res ? res : out_data_reg);
        skid_data_next = skid_load ? res : skid_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_DOSAGE;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: hdl/gus_checker.sv
// port-level checker for the genotype unpack block, bound to the top level
// depends on gus_pkg and genotype_unpack_standardize_macros.svh
`include "genotype_unpack_standardize_macros.svh"

module gus_checker
    import gus_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_stall,
    input in_req_t  in_data,
    input logic     out_valid,
    input logic     out_stall,
    input out_req_t out_data
);

    `GUS_ASSERT_NEXT(a_stalled_result_holds, out_valid && out_stall, out_valid && $stable(out_data), "stalled result request changed")

    // every genotype request lands in the output register or behind it
    `GUS_ASSERT_NEXT(a_geno_gives_result, in_valid && !in_stall && (in_data.kind == KIND_GENO), out_valid, "genotype request left no result")

    `GUS_ASSERT_IMPLY(a_count_range, out_valid, out_data.valid_count <= SIB_W'(SAMPLES_PER_BYTE), "valid_count above four")

    `GUS_ASSERT_IMPLY(a_tail_zero, out_valid, (out_data.valid_count > SIB_W'(1) || out_data.value1 == '0) && (out_data.valid_count > SIB_W'(2) || out_data.value2 == '0) && (out_data.valid_count > SIB_W'(3) || out_data.value3 == '0), "value past valid_count not zero")

    `GUS_ASSERT_IMPLY(a_degenerate_zero, out_valid && out_data.degenerate, out_data.value0 == '0 && out_data.value1 == '0 && out_data.value2 == '0 && out_data.value3 == '0, "degenerate result with nonzero value")

endmodule

bind genotype_unpack_standardize gus_checker u_gus_checker (.*);

FILE: dv/tb.sv
// testbench for genotype_unpack_standardize: directed table, then random snp runs
// scored against a local decoder and table builder
// depends on gus_pkg and the rtl of the block
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gus_pkg::*;

    // the unused mode code decodes as dosage
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    localparam logic signed [VAL_W-1:0] ZERO_Q = '0;
    localparam logic signed [VAL_W-1:0] ONE_Q  = 28'sh0010000;
    localparam logic signed [VAL_W-1:0] TWO_Q  = 28'sh0020000;
    localparam logic signed [VAL_W-1:0] MONE_Q = -28'sh0010000;

    // settle time that covers a table unit run after a snp-start request
    localparam int SETTLE_CYCLES = 160;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 82;
    localparam int NUM_ROWS      = 23;

    typedef struct {
        logic [MODE_W-1:0] mode;
        in_req_t           req;
        bit                typed;
        out_req_t          want;
    } vec_row_t;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     cfg_write = 1'b0;
    logic [MODE_W-1:0] cfg_data = MODE_DOSAGE;
    logic     in_valid  = 1'b0;
    logic     in_stall;
    in_req_t  in_data   = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    out_req_t out_data;

    logic signed [VAL_W-1:0] std_tbl [SAMPLES_PER_BYTE] = '{default: '0};
    logic              freq_degenerate = 1'b0;
    logic [MODE_W-1:0] mode_now = MODE_DOSAGE;
    out_req_t          decoded_q [$];
    int                fail_count = 0;
    int                send_gap_pct = 0;
    int                recv_stall_pct = 0;
    logic              holding = 1'b0;
    event              hold_off_ev;

    vec_row_t dir_rows [NUM_ROWS] = '{
        '{MODE_DOSAGE, '{KIND_GENO, 16'h0000, 8'hE4, 3'd4}, 1'b1,
          '{ZERO_Q, ZERO_Q, ONE_Q, TWO_Q, 3'd4, 1'b0}},
        // counts above four clip to four
        '{MODE_DOSAGE, '{KIND_GENO, 16'hFFFF, 8'hFF, 3'd7}, 1'b1,
          '{TWO_Q, TWO_Q, TWO_Q, TWO_Q, 3'd4, 1'b0}},
        '{MODE_DOSAGE, '{KIND_GENO, 16'h0000, 8'h00, 3'd0}, 1'b1,
          '{ZERO_Q, ZERO_Q, ZERO_Q, ZERO_Q, 3'd0, 1'b0}},
        '{MODE_DOSAGE, '{KIND_GENO, 16'h0000, 8'h1B, 3'd1}, 1'b1,
          '{TWO_Q, ZERO_Q, ZERO_Q, ZERO_Q, 3'd1, 1'b0}},
        // standardized table is all zero out of reset
        '{MODE_STD, '{KIND_GENO, 16'h0000, 8'hE4, 3'd4}, 1'b1,
          '{ZERO_Q, ZERO_Q, ZERO_Q, ZERO_Q, 3'd4, 1'b0}},
        '{MODE_STD, '{KIND_SNP, 16'h0000, 8'h00, 3'd0}, 1'b0, '0},
        '{MODE_STD, '{KIND_GENO, 16'h0000, 8'hFF, 3'd4}, 1'b1,
          '{ZERO_Q, ZERO_Q, ZERO_Q, ZERO_Q, 3'd4, 1'b1}},
        '{MODE_STD, '{KIND_SNP, 16'h8000, 8'hFF, 3'd7}, 1'b0, '0},
        '{MODE_STD, '{KIND_GENO, 16'h0000, 8'hE4, 3'd4}, 1'b0, '0},
        '{MODE_STD, '{KIND_SNP, 16'h0001, 8'h00, 3'd0}, 1'b0, '0},
        '{MODE_STD, '{KIND_GENO, 16'h0000, 8'h39, 3'd3}, 1'b0, '0},
        '{MODE_STD, '{KIND_SNP, 16'hFFFF, 8'h00, 3'd0}, 1'b0, '0},
        '{MODE_STD, '{KIND_GENO, 16'h0000, 8'hC6, 3'd2}, 1'b0, '0},
        '{MODE_STD, '{KIND_SNP, 16'h3039, 8'hFF, 3'd7}, 1'b0, '0},
        '{MODE_STD, '{KIND_GENO, 16'hFFFF, 8'hE4, 3'd4}, 1'b0, '0},
        '{MODE_CENTER, '{KIND_GENO, 16'h0000, 8'hE4, 3'd4}, 1'b1,
          '{MONE_Q, ZERO_Q, ZERO_Q, ONE_Q, 3'd4, 1'b0}},
        // snp start outside standardized mode still rebuilds the table
        '{MODE_CENTER, '{KIND_SNP, 16'h0000, 8'h00, 3'd0}, 1'b0, '0},
        '{MODE_CENTER, '{KIND_GENO, 16'h0000, 8'hFF, 3'd5}, 1'b1,
          '{ONE_Q, ONE_Q, ONE_Q, ONE_Q, 3'd4, 1'b0}},
        '{MODE_SPARE, '{KIND_GENO, 16'h0000, 8'hE4, 3'd4}, 1'b1,
          '{ZERO_Q, ZERO_Q, ONE_Q, TWO_Q, 3'd4, 1'b0}},
        '{MODE_SPARE, '{KIND_GENO, 16'h0000, 8'h00, 3'd6}, 1'b1,
          '{ZERO_Q, ZERO_Q, ZERO_Q, ZERO_Q, 3'd4, 1'b0}},
        '{MODE_STD, '{KIND_GENO, 16'h0000, 8'hB1, 3'd4}, 1'b1,
          '{ZERO_Q, ZERO_Q, ZERO_Q, ZERO_Q, 3'd4, 1'b1}},
        '{MODE_STD, '{KIND_SNP, 16'h9C40, 8'h00, 3'd0}, 1'b0, '0},
        '{MODE_STD, '{KIND_GENO, 16'h0000, 8'h9C, 3'd4}, 1'b0, '0}
    };

    genotype_unpack_standardize DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // (k - 2p) / sqrt(2p(1-p)) in fixed point, rounded half up and saturated
    function automatic logic signed [VAL_W-1:0] std_value(input logic [63:0] k,
                                                          input logic [63:0] a,
                                                          input logic [63:0] root,
                                                          input int e);
        logic [63:0]  ks;
        logic [63:0]  m;
        logic [127:0] q;
        logic [127:0] mag;
        logic signed [VAL_W-1:0] v;
        bit           neg;
        ks  = k << FREQ_FRAC_BITS_DEF;
        neg = ks < 2 * a;
        m   = neg ? 2 * a - ks : ks - 2 * a;
        if (m == 0)
            return ZERO_Q;
        q   = (128'(m) << (OUT_FRAC_BITS_DEF + e + 1)) / 128'(root);
        mag = (q + 1) >> 1;
        if (neg && mag >= 128'h800_0000)
            return VAL_MIN;
        if (!neg && mag > 128'h7FF_FFFF)
            return VAL_MAX;
        v = mag[VAL_W-1:0];
        return neg ? -v : v;
    endfunction

    task automatic build_std_table(input logic [FREQ_W-1:0] freq);
        logic [63:0] a;
        logic [63:0] s;
        logic [63:0] d;
        logic [63:0] root;
        logic [63:0] trial;
        int          e;
        a = 64'(freq);
        s = 64'd1 << FREQ_FRAC_BITS_DEF;
        if (a == 0 || a >= s)
        begin
            freq_degenerate = 1'b1;
            std_tbl = '{default: '0};
            return;
        end
        freq_degenerate = 1'b0;
        d = 2 * a * (s - a);
        e = 0;
        while (d < (64'd1 << 60))
        begin
            d = d << 2;
            e++;
        end
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= d)
                root = trial;
        end
        std_tbl[0] = std_value(64'd0, a, root, e);
        std_tbl[1] = ZERO_Q;
        std_tbl[2] = std_value(64'd1, a, root, e);
        std_tbl[3] = std_value(64'd2, a, root, e);
    endtask

    task automatic decode_genotypes(input in_req_t r);
        logic signed [VAL_W-1:0] lut [SAMPLES_PER_BYTE];
        logic signed [VAL_W-1:0] v [SAMPLES_PER_BYTE];
        logic [SIB_W-1:0] n;
        out_req_t o;
        if (r.kind == KIND_SNP)
        begin
            build_std_table(r.allele_freq);
            return;
        end
        case (mode_now)
            MODE_STD:    lut = std_tbl;
            MODE_CENTER: lut = '{MONE_Q, ZERO_Q, ZERO_Q, ONE_Q};
            default:     lut = '{ZERO_Q, ZERO_Q, ONE_Q, TWO_Q};
        endcase
        n = (r.samples_in_byte > SAMPLES_PER_BYTE) ? SIB_W'(SAMPLES_PER_BYTE)
                                                   : r.samples_in_byte;
        for (int j = 0; j < SAMPLES_PER_BYTE; j++)
            v[j] = (j < n) ? lut[r.geno_byte[2*j +: 2]] : ZERO_Q;
        o.value0      = v[0];
        o.value1      = v[1];
        o.value2      = v[2];
        o.value3      = v[3];
        o.valid_count = n;
        o.degenerate  = (mode_now == MODE_STD) && freq_degenerate;
        decoded_q.push_back(o);
    endtask

    task automatic push_request(input in_req_t r);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_mode(input logic [MODE_W-1:0] m);
        wait_drained();
        cfg_write <= 1'b1;
        cfg_data  <= m;
        @(posedge clk);
        cfg_write <= 1'b0;
        mode_now = m;
    endtask

    task automatic check_field(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        out_req_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (decoded_q.size() == 0)
            begin
                $error("result request with nothing expected");
                fail_count++;
            end
            else
            begin
                want = decoded_q.pop_front();
                check_field("value0", want.value0, out_data.value0);
                check_field("value1", want.value1, out_data.value1);
                check_field("value2", want.value2, out_data.value2);
                check_field("value3", want.value3, out_data.value3);
                check_field("valid_count", want.valid_count, out_data.valid_count);
                check_field("degenerate", want.degenerate, out_data.degenerate);
            end
        end
    end

    always @(posedge clk)
    begin
        out_stall <= holding || ($urandom_range(99) < recv_stall_pct);
    end

    // one long receiver hold-off so the output buffer fills and in_stall rises
    initial
    begin
        @(hold_off_ev);
        @(posedge clk);
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding <= 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("genotype_unpack_standardize test failed");
        $finish;
    end

    initial
    begin
        in_req_t           req;
        int                sent;
        int                run_len;
        logic [MODE_W-1:0] mode_order [4];
        int                gap_pct [3];
        int                stall_pct [3];
        mode_order = '{MODE_STD, MODE_DOSAGE, MODE_CENTER, MODE_SPARE};
        gap_pct    = '{7, 72, 0};
        stall_pct  = '{72, 7, 0};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
        begin
            if (dir_rows[i].mode != mode_now)
                set_mode(dir_rows[i].mode);
            push_request(dir_rows[i].req);
            if (dir_rows[i].typed)
                decoded_q.push_back(dir_rows[i].want);
            else
                decode_genotypes(dir_rows[i].req);
        end

        for (int pat = 0; pat < 3; pat++)
        begin
            send_gap_pct   = gap_pct[pat];
            recv_stall_pct = stall_pct[pat];
            for (int mi = 0; mi < 4; mi++)
            begin
                set_mode(mode_order[mi]);
                if (pat == 2 && mi == 0)
                    -> hold_off_ev;
                sent = 0;
                while (sent < PHASE_ITEMS)
                begin
                    if ($urandom_range(19) == 0)
                    begin
                        // stray request with any field values
                        req.kind            = 1'($urandom_range(1));
                        req.allele_freq     = FREQ_W'($urandom);
                        req.geno_byte       = GENO_W'($urandom);
                        req.samples_in_byte = SIB_W'($urandom_range(7));
                        push_request(req);
                        decode_genotypes(req);
                        sent++;
                    end
                    else
                    begin
                        // snp start then a run of bytes, last byte holding one to four samples
                        req.kind            = KIND_SNP;
                        req.geno_byte       = GENO_W'($urandom);
                        req.samples_in_byte = SIB_W'($urandom_range(7));
                        case ($urandom_range(9))
                            0:       req.allele_freq = '0;
                            1:       req.allele_freq = '1;
                            2:       req.allele_freq = FREQ_W'($urandom_range(16, 1));
                            3:       req.allele_freq = 16'hFFFF
                                                       - FREQ_W'($urandom_range(15));
                            default: req.allele_freq = FREQ_W'($urandom);
                        endcase
                        push_request(req);
                        decode_genotypes(req);
                        sent++;
                        run_len = $urandom_range(12, 1);
                        for (int b = 0; b < run_len; b++)
                        begin
                            req.kind            = KIND_GENO;
                            req.allele_freq     = FREQ_W'($urandom);
                            req.geno_byte       = GENO_W'($urandom);
                            req.samples_in_byte = (b == run_len - 1)
                                                ? SIB_W'($urandom_range(4, 1))
                                                : SIB_W'(4);
                            push_request(req);
                            decode_genotypes(req);
                            sent++;
                        end
                    end
                end
            end
        end

        wait_drained();
        if (fail_count == 0)
            $display("genotype_unpack_standardize test passed");
        else
            $display("genotype_unpack_standardize test failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/gus_pkg.sv
hdl/gus_table_calc.sv
hdl/genotype_unpack_standardize.sv
hdl/gus_checker.sv
dv/tb.sv
